@@ rtl/core/bpdr_pkg.sv @@
`default_nettype none

package bpdr_pkg;

   // Field widths fixed by the item formats.
   localparam int COORD_W = 32;
   localparam int COEF_W  = 24;
   localparam int DIST_W  = 32;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;

   // Product of one coefficient and one coordinate, and the numerator sum.
   localparam int PROD_W = COEF_W + COORD_W;
   localparam int NUM_W  = PROD_W + 2;
   localparam int MAG_W  = PROD_W;

   // Square of one coefficient, sum of squares, radicand and norm.
   localparam int SQ_W   = 2 * COEF_W - 1;
   localparam int SSUM_W = SQ_W + 1;
   localparam int RAD_W  = 64;
   localparam int NORM_W = 32;
   localparam int ITER_W = 5;

   // One quotient bit per divider stage.
   localparam int DIV_STEPS = 32;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_A      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_B      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_C      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_OFFSET = 2'd3;

   localparam logic [COEF_W-1:0] PLANE_C_RESET = 24'd65536;

   typedef struct packed {
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic signed [COORD_W-1:0] box_min_z;
      logic signed [COORD_W-1:0] box_max_x;
      logic signed [COORD_W-1:0] box_max_y;
      logic signed [COORD_W-1:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] nearest_distance;
      logic signed [DIST_W-1:0] farthest_distance;
      logic                     saturated;
      logic                     degenerate_plane;
   } rsp_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_SQUARE,
      SQ_SUM,
      SQ_ITER
   } sq_state_type;

endpackage

`default_nettype wire

@@ rtl/core/box_plane_distance_range.sv @@
`default_nettype none

// Box to plane distance range. Each item is an axis-aligned box (min and max
// corner, signed Q16.16); the block returns the least and greatest signed
// distance of the box's eight corners to the plane a*x + b*y + c*z = d, in
// signed Q16.16, truncated toward zero and saturated, with a flag for
// clipping and a flag for a zero normal (distances then read zero). One item
// is accepted per clock cycle unless the norm is being recomputed or the
// output stage is full. Each item passes the input register, products,
// per-axis extremes, sums, divider entry, a pipelined divider that makes one
// quotient bit per stage, a stage of sign and saturation, and the output
// register. After reset, and after every write to plane_a, plane_b or
// plane_c, the norm sqrt(a^2 + b^2 + c^2) is recomputed by an iterative unit
// that makes one result bit per cycle; req_ready is low while it works.
// Writing plane_offset takes effect at once. Registers may only be written
// while no item is in flight. A two-entry output stage lets one more result
// leave the pipeline while a result waits on rsp_ready.
module box_plane_distance_range (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire bpdr_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output bpdr_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_write_en,
   input  wire logic [bpdr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bpdr_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int NS = bpdr_pkg::DIV_STEPS;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic signed [bpdr_pkg::COEF_W-1:0]  plane_a_ff;
   logic signed [bpdr_pkg::COEF_W-1:0]  plane_b_ff;
   logic signed [bpdr_pkg::COEF_W-1:0]  plane_c_ff;
   logic signed [bpdr_pkg::COORD_W-1:0] plane_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_a_ff      <= '0;
         plane_b_ff      <= '0;
         plane_c_ff      <= bpdr_pkg::PLANE_C_RESET;
         plane_offset_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            bpdr_pkg::CSR_PLANE_A:      plane_a_ff <= csr_wdata[bpdr_pkg::COEF_W-1:0];
            bpdr_pkg::CSR_PLANE_B:      plane_b_ff <= csr_wdata[bpdr_pkg::COEF_W-1:0];
            bpdr_pkg::CSR_PLANE_C:      plane_c_ff <= csr_wdata[bpdr_pkg::COEF_W-1:0];
            bpdr_pkg::CSR_PLANE_OFFSET: plane_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A change to any normal coefficient invalidates the norm.
   logic coef_write;
   assign coef_write = csr_write_en && (csr_index == bpdr_pkg::CSR_PLANE_A ||
                                        csr_index == bpdr_pkg::CSR_PLANE_B ||
                                        csr_index == bpdr_pkg::CSR_PLANE_C);

   // ---------------------------------------------------------------------
   // Norm unit: squares, then their sum shifted to 48 fraction bits, then a
   // bit-by-bit integer square root.
   // ---------------------------------------------------------------------
   bpdr_pkg::sq_state_type sq_state_ff;
   bpdr_pkg::sq_state_type sq_state_in;

   logic [bpdr_pkg::SQ_W-1:0]   sq_a_ff;
   logic [bpdr_pkg::SQ_W-1:0]   sq_b_ff;
   logic [bpdr_pkg::SQ_W-1:0]   sq_c_ff;
   logic [bpdr_pkg::RAD_W-1:0]  sq_v_ff;
   logic [bpdr_pkg::RAD_W-1:0]  sq_res_ff;
   logic [bpdr_pkg::ITER_W-1:0] sq_k_ff;
   logic [bpdr_pkg::NORM_W-1:0] norm_ff;
   logic                        degen_ff;

   logic sq_busy;
   logic sq_do_square;
   logic sq_do_sum;
   logic sq_do_iter;

   always_comb begin
      sq_state_in = sq_state_ff;
      case (sq_state_ff)
         bpdr_pkg::SQ_IDLE:   sq_state_in = bpdr_pkg::SQ_IDLE;
         bpdr_pkg::SQ_SQUARE: sq_state_in = bpdr_pkg::SQ_SUM;
         bpdr_pkg::SQ_SUM:    sq_state_in = bpdr_pkg::SQ_ITER;
         bpdr_pkg::SQ_ITER: begin
            if (sq_k_ff == '0) begin
               sq_state_in = bpdr_pkg::SQ_IDLE;
            end
         end
         default:             sq_state_in = bpdr_pkg::SQ_SQUARE;
      endcase
      if (coef_write) begin
         sq_state_in = bpdr_pkg::SQ_SQUARE;
      end
   end

   always_comb begin
      sq_busy      = 1'b1;
      sq_do_square = 1'b0;
      sq_do_sum    = 1'b0;
      sq_do_iter   = 1'b0;
      case (sq_state_ff)
         bpdr_pkg::SQ_IDLE:   sq_busy      = 1'b0;
         bpdr_pkg::SQ_SQUARE: sq_do_square = 1'b1;
         bpdr_pkg::SQ_SUM:    sq_do_sum    = 1'b1;
         bpdr_pkg::SQ_ITER:   sq_do_iter   = 1'b1;
         default:             sq_busy      = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_state_ff <= bpdr_pkg::SQ_SQUARE;
      end else begin
         sq_state_ff <= sq_state_in;
      end
   end

   logic signed [2*bpdr_pkg::COEF_W-1:0] sqa_full;
   logic signed [2*bpdr_pkg::COEF_W-1:0] sqb_full;
   logic signed [2*bpdr_pkg::COEF_W-1:0] sqc_full;
   logic [bpdr_pkg::SSUM_W-1:0]          ssum;
   logic [bpdr_pkg::RAD_W-1:0]           sq_bit;
   logic [bpdr_pkg::RAD_W-1:0]           sq_trial;
   logic [bpdr_pkg::RAD_W-1:0]           sq_res_in;
   logic [bpdr_pkg::RAD_W-1:0]           sq_v_in;

   assign sqa_full = plane_a_ff * plane_a_ff;
   assign sqb_full = plane_b_ff * plane_b_ff;
   assign sqc_full = plane_c_ff * plane_c_ff;
   assign ssum = bpdr_pkg::SSUM_W'(sq_a_ff) + bpdr_pkg::SSUM_W'(sq_b_ff)
               + bpdr_pkg::SSUM_W'(sq_c_ff);

   always_comb begin
      sq_bit   = bpdr_pkg::RAD_W'(1) << {sq_k_ff, 1'b0};
      sq_trial = sq_res_ff + sq_bit;
      if (sq_v_ff >= sq_trial) begin
         sq_v_in   = sq_v_ff - sq_trial;
         sq_res_in = (sq_res_ff >> 1) + sq_bit;
      end else begin
         sq_v_in   = sq_v_ff;
         sq_res_in = sq_res_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_do_square) begin
         sq_a_ff <= sqa_full[bpdr_pkg::SQ_W-1:0];
         sq_b_ff <= sqb_full[bpdr_pkg::SQ_W-1:0];
         sq_c_ff <= sqc_full[bpdr_pkg::SQ_W-1:0];
      end
      if (sq_do_sum) begin
         sq_v_ff   <= {ssum, 16'd0};
         sq_res_ff <= '0;
         sq_k_ff   <= '1;
         degen_ff  <= (ssum == '0);
      end
      if (sq_do_iter) begin
         sq_v_ff   <= sq_v_in;
         sq_res_ff <= sq_res_in;
         sq_k_ff   <= sq_k_ff - 1'b1;
         if (sq_k_ff == '0) begin
            norm_ff <= sq_res_in[bpdr_pkg::NORM_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control. The whole pipeline moves together unless the output
   // stage is full (a result waiting plus one more held in the skid entry).
   // ---------------------------------------------------------------------
   logic pipe_en;
   logic skid_v_ff;
   logic req_fire;

   assign pipe_en   = !skid_v_ff;
   assign req_ready = pipe_en && !sq_busy;
   assign req_fire  = req_valid && req_ready;

   // Stage 1: registered box.
   bpdr_pkg::req_type box_ff;
   logic              v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         box_ff <= req_data;
      end
   end

   // Stage 2: the six coefficient times coordinate products.
   logic signed [bpdr_pkg::PROD_W-1:0] prod_ff [0:5];
   logic                               v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (pipe_en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         prod_ff[0] <= plane_a_ff * box_ff.box_min_x;
         prod_ff[1] <= plane_b_ff * box_ff.box_min_y;
         prod_ff[2] <= plane_c_ff * box_ff.box_min_z;
         prod_ff[3] <= plane_a_ff * box_ff.box_max_x;
         prod_ff[4] <= plane_b_ff * box_ff.box_max_y;
         prod_ff[5] <= plane_c_ff * box_ff.box_max_z;
      end
   end

   // Stage 3: per-axis least and greatest term. The norm is positive, so
   // the extreme numerators give the extreme distances.
   logic signed [bpdr_pkg::PROD_W-1:0] axmin_ff [0:2];
   logic signed [bpdr_pkg::PROD_W-1:0] axmax_ff [0:2];
   logic                               v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (pipe_en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 3; i++) begin
            if (prod_ff[i] < prod_ff[i+3]) begin
               axmin_ff[i] <= prod_ff[i];
               axmax_ff[i] <= prod_ff[i+3];
            end else begin
               axmin_ff[i] <= prod_ff[i+3];
               axmax_ff[i] <= prod_ff[i];
            end
         end
      end
   end

   // Stage 4: numerators with 32 fraction bits, offset subtracted.
   logic signed [bpdr_pkg::NUM_W-1:0] nmin_ff;
   logic signed [bpdr_pkg::NUM_W-1:0] nmax_ff;
   logic signed [bpdr_pkg::NUM_W-1:0] offs_wide;
   logic                              v4_ff;

   assign offs_wide = {{(bpdr_pkg::NUM_W-bpdr_pkg::COORD_W-16){plane_offset_ff[31]}},
                       plane_offset_ff, 16'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (pipe_en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         nmin_ff <= bpdr_pkg::NUM_W'(axmin_ff[0]) + bpdr_pkg::NUM_W'(axmin_ff[1])
                  + bpdr_pkg::NUM_W'(axmin_ff[2]) - offs_wide;
         nmax_ff <= bpdr_pkg::NUM_W'(axmax_ff[0]) + bpdr_pkg::NUM_W'(axmax_ff[1])
                  + bpdr_pkg::NUM_W'(axmax_ff[2]) - offs_wide;
      end
   end

   // ---------------------------------------------------------------------
   // Divider. Entry (index 0) takes sign and magnitude; the dividend is the
   // magnitude shifted up by 8 bits. If its upper 32 bits already reach the
   // norm, the quotient needs more than 32 bits and the result saturates.
   // Each following stage shifts in one dividend bit and makes one quotient
   // bit. Lane 0 carries the nearest distance, lane 1 the farthest.
   // ---------------------------------------------------------------------
   logic [31:0] dv_rem_ff [0:NS][0:1];
   logic [31:0] dv_lo_ff  [0:NS][0:1];
   logic [31:0] dv_q_ff   [0:NS][0:1];
   logic        dv_neg_ff [0:NS][0:1];
   logic        dv_ovf_ff [0:NS][0:1];
   logic        dv_v_ff   [0:NS];

   logic signed [bpdr_pkg::NUM_W-1:0] ent_num [0:1];
   logic [bpdr_pkg::NUM_W-1:0]        ent_abs [0:1];
   logic [63:0]                       ent_div [0:1];

   always_comb begin
      ent_num[0] = nmin_ff;
      ent_num[1] = nmax_ff;
      for (int j = 0; j < 2; j++) begin
         ent_abs[j] = ent_num[j][bpdr_pkg::NUM_W-1] ? -ent_num[j] : ent_num[j];
         ent_div[j] = {ent_abs[j][bpdr_pkg::MAG_W-1:0], 8'd0};
      end
   end

   logic [32:0] dv_cand [0:NS-1][0:1];
   logic        dv_ge   [0:NS-1][0:1];

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         for (int j = 0; j < 2; j++) begin
            dv_cand[k][j] = {dv_rem_ff[k][j], dv_lo_ff[k][j][31]};
            dv_ge[k][j]   = dv_cand[k][j] >= {1'b0, norm_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NS; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
      end else if (pipe_en) begin
         dv_v_ff[0] <= v4_ff;
         for (int k = 0; k < NS; k++) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < 2; j++) begin
            dv_rem_ff[0][j] <= ent_div[j][63:32];
            dv_lo_ff[0][j]  <= ent_div[j][31:0];
            dv_q_ff[0][j]   <= '0;
            dv_neg_ff[0][j] <= ent_num[j][bpdr_pkg::NUM_W-1];
            dv_ovf_ff[0][j] <= ent_div[j][63:32] >= norm_ff;
         end
         for (int k = 0; k < NS; k++) begin
            for (int j = 0; j < 2; j++) begin
               dv_rem_ff[k+1][j] <= dv_ge[k][j] ? 32'(dv_cand[k][j] - {1'b0, norm_ff})
                                                : dv_cand[k][j][31:0];
               dv_lo_ff[k+1][j]  <= {dv_lo_ff[k][j][30:0], 1'b0};
               dv_q_ff[k+1][j]   <= {dv_q_ff[k][j][30:0], dv_ge[k][j]};
               dv_neg_ff[k+1][j] <= dv_neg_ff[k][j];
               dv_ovf_ff[k+1][j] <= dv_ovf_ff[k][j];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Final stage: sign, saturation and the zero-normal case.
   // ---------------------------------------------------------------------
   logic [31:0]       fin_val [0:1];
   logic              fin_sat [0:1];
   bpdr_pkg::rsp_type fin_in;
   bpdr_pkg::rsp_type fin_ff;
   logic              fin_v_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         if (dv_neg_ff[NS][j]) begin
            fin_sat[j] = dv_ovf_ff[NS][j] || (dv_q_ff[NS][j] > 32'h8000_0000);
            fin_val[j] = fin_sat[j] ? 32'h8000_0000 : -dv_q_ff[NS][j];
         end else begin
            fin_sat[j] = dv_ovf_ff[NS][j] || dv_q_ff[NS][j][31];
            fin_val[j] = fin_sat[j] ? 32'h7FFF_FFFF : dv_q_ff[NS][j];
         end
      end
      if (degen_ff) begin
         fin_in.nearest_distance  = '0;
         fin_in.farthest_distance = '0;
         fin_in.saturated         = 1'b0;
         fin_in.degenerate_plane  = 1'b1;
      end else begin
         fin_in.nearest_distance  = fin_val[0];
         fin_in.farthest_distance = fin_val[1];
         fin_in.saturated         = fin_sat[0] || fin_sat[1];
         fin_in.degenerate_plane  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (pipe_en) begin
         fin_v_ff <= dv_v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fin_ff <= fin_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output register plus one skid entry. When the pipeline moves, the
   // item leaving the final stage goes to the output register if that is
   // free or being taken, else to the skid entry, which then freezes the
   // pipeline until the output drains it.
   // ---------------------------------------------------------------------
   bpdr_pkg::rsp_type out_ff;
   bpdr_pkg::rsp_type skid_ff;
   logic              out_v_ff;
   logic              out_take;

   assign out_take = rsp_ready || !out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (fin_v_ff) begin
         if (out_take) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (fin_v_ff) begin
         if (out_take) begin
            out_ff <= fin_ff;
         end else begin
            skid_ff <= fin_ff;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

@@ rtl/core/bpdr_checker.sv @@
`default_nettype none

module bpdr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire bpdr_pkg::rsp_type               rsp_data,
   input wire logic                            csr_write_en,
   input wire logic [bpdr_pkg::CSR_IDX_W-1:0]  csr_index
);

   // The norm is recomputed after reset, so no item is taken right away.
   a_reset_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("item taken while norm is being computed after reset");

   // A new normal coefficient makes the block refuse items while it works.
   a_coef_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index == bpdr_pkg::CSR_PLANE_A ||
                       csr_index == bpdr_pkg::CSR_PLANE_B ||
                       csr_index == bpdr_pkg::CSR_PLANE_C) |=> !req_ready)
      else $error("item taken before the new norm is ready");

   // A zero normal gives zero distances and no clipping.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate_plane |->
         rsp_data.nearest_distance == '0 && rsp_data.farthest_distance == '0 &&
         !rsp_data.saturated)
      else $error("zero-normal result is not zero");

   // Nearest never exceeds farthest.
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.nearest_distance <= rsp_data.farthest_distance)
      else $error("nearest distance above farthest distance");

   // A result waiting on the consumer stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

endmodule

bind box_plane_distance_range bpdr_checker u_bpdr_checker (.*);

`default_nettype wire

@@ tb/sv/box_plane_distance_range_tb.sv @@
`timescale 1ns / 100ps

// Tracks planes and predicts distance ranges of accepted boxes.
class range_scoreboard;
   logic signed [23:0] coef_a, coef_b, coef_c;
   logic signed [31:0] offset_d;
   bpdr_pkg::rsp_type pending_ranges[$];
   int mismatches;
   int checked;

   function new();
      coef_a = 0;
      coef_b = 0;
      coef_c = 24'sd65536;
      offset_d = 0;
      mismatches = 0;
      checked = 0;
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
         bpdr_pkg::CSR_PLANE_A: coef_a = value[23:0];
         bpdr_pkg::CSR_PLANE_B: coef_b = value[23:0];
         bpdr_pkg::CSR_PLANE_C: coef_c = value[23:0];
         bpdr_pkg::CSR_PLANE_OFFSET: offset_d = value;
         default: ;
      endcase
   endfunction

   function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // The numerator holds 32 fraction bits and the norm 24, so the quotient
   // gets 8 extra fraction bits from the remainder.
   function longint scale_to_q16(longint num, longint unsigned norm, inout bit clipped);
      longint unsigned mag, quo, rem, res, limit;
      bit neg;
      neg = num < 0;
      mag = neg ? longint'(-num) : num;
      quo = mag / norm;
      rem = mag % norm;
      res = (quo << 8) + ((rem << 8) / norm);
      limit = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
      if (res > limit) begin
         res = limit;
         clipped = 1;
      end
      return neg ? -longint'(res) : longint'(res);
   endfunction

   function void note_box(bpdr_pkg::req_type box);
      longint ca, cb, cc, lo, hi, p, q;
      longint unsigned sumsq, norm;
      bpdr_pkg::rsp_type r;
      bit clipped;
      ca = coef_a;
      cb = coef_b;
      cc = coef_c;
      sumsq = ca * ca + cb * cb + cc * cc;
      clipped = 0;
      r = '0;
      if (sumsq == 0) begin
         r.degenerate_plane = 1;
      end else begin
         lo = 0;
         hi = 0;
         p = ca * longint'(box.box_min_x); q = ca * longint'(box.box_max_x);
         lo += (p < q) ? p : q; hi += (p < q) ? q : p;
         p = cb * longint'(box.box_min_y); q = cb * longint'(box.box_max_y);
         lo += (p < q) ? p : q; hi += (p < q) ? q : p;
         p = cc * longint'(box.box_min_z); q = cc * longint'(box.box_max_z);
         lo += (p < q) ? p : q; hi += (p < q) ? q : p;
         lo -= longint'(offset_d) * 65536;
         hi -= longint'(offset_d) * 65536;
         norm = int_sqrt(sumsq << 16);
         r.nearest_distance = 32'(scale_to_q16(lo, norm, clipped));
         r.farthest_distance = 32'(scale_to_q16(hi, norm, clipped));
         r.saturated = clipped;
      end
      pending_ranges = {pending_ranges, r};
   endfunction

   function void check_range(bpdr_pkg::rsp_type got);
      bpdr_pkg::rsp_type want;
      if (pending_ranges.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result item %h", got);
         return;
      end
      want = pending_ranges.pop_front();
      checked++;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch: near %0d/%0d far %0d/%0d sat %b/%b degen %b/%b (exp/got)",
               want.nearest_distance, got.nearest_distance,
               want.farthest_distance, got.farthest_distance,
               want.saturated, got.saturated,
               want.degenerate_plane, got.degenerate_plane);
      end
   endfunction
endclass

module box_plane_distance_range_tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 60;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   bpdr_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   bpdr_pkg::rsp_type rsp_data;
   logic csr_write_en;
   logic [bpdr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bpdr_pkg::CSR_W-1:0] csr_wdata;

   range_scoreboard board;
   int idle_cycles;
   int boxes_sent;
   int plane_count;
   bit rsp_stall_on;

   box_plane_distance_range uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, with an occasional long one.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // A coordinate biased toward the extremes and small values.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 65535) - 32768;
         3, 4: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic bpdr_pkg::req_type random_box();
      bpdr_pkg::req_type b;
      b.box_min_x = pick_coord();
      b.box_min_y = pick_coord();
      b.box_min_z = pick_coord();
      b.box_max_x = pick_coord();
      b.box_max_y = pick_coord();
      b.box_max_z = pick_coord();
      return b;
   endfunction

   // Presents one box and holds it until the block takes it. Valid stays
   // high after the accepting edge so that boxes can follow back to back;
   // a gap or a drain lowers it.
   task automatic send_box(bpdr_pkg::req_type box);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= box;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_box(box);
      boxes_sent++;
   endtask

   // Waits until every predicted result has come back, then lets the
   // pipeline settle before any register write.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending_ranges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [bpdr_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.set_reg(idx, value);
   endtask

   task automatic load_plane(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                             logic [31:0] d);
      wait_drained();
      write_reg(bpdr_pkg::CSR_PLANE_A, {8'h00, a});
      write_reg(bpdr_pkg::CSR_PLANE_B, {8'h00, b});
      write_reg(bpdr_pkg::CSR_PLANE_C, {8'h00, c});
      write_reg(bpdr_pkg::CSR_PLANE_OFFSET, d);
      csr_write_en <= 1'b0;
      plane_count++;
   endtask

   // Result side: random stalls, and phases with none at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_range(rsp_data);
         if (!rsp_stall_on) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 99) < 70);
      end
   end

   // Counts cycles in which no item moves on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d results outstanding", board.pending_ranges.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      bpdr_pkg::req_type box;
      logic [31:0] rnd_a, rnd_b, rnd_c;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = bpdr_pkg::CSR_PLANE_A;
      csr_wdata = '0;
      boxes_sent = 0;
      plane_count = 0;
      rsp_stall_on = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset plane z = 0: extremes, swapped bounds.
      box = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
      send_box(box);
      box = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
      send_box(box);
      box = '{0, 0, 32'sh0001_0000, 0, 0, -32'sh0001_0000};
      send_box(box);

      // A zero normal yields zero distances and the degenerate flag.
      load_plane(24'd0, 24'd0, 24'd0, 32'h0001_0000);
      send_box(box);
      send_box(random_box());

      // Smallest coefficients with a huge box force saturation both ways.
      load_plane(24'h80_0000, 24'h80_0000, 24'h80_0000, 32'h8000_0000);
      box = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
      send_box(box);
      load_plane(24'h7f_ffff, 24'h00_0001, 24'h80_0000, 32'h7fff_ffff);
      send_box(box);
      send_box(random_box());
      load_plane(24'h00_0001, 24'h00_0000, 24'h00_0000, 32'h0000_0000);
      send_box(box);
      box = '{32'sh0000_0001, 0, 0, 32'sh0000_0001, 0, 0};
      send_box(box);
      load_plane(24'hff_ffff, 24'h01_0000, 24'h00_0000, 32'hffff_0000);
      send_box(box);
      send_box(random_box());
      send_box(random_box());

      // Random phases with fresh planes; stalls on the result side
      // switch on and off between phases.
      for (int phase = 0; phase < 40; phase++) begin
         rnd_a = $urandom;
         rnd_b = $urandom;
         rnd_c = $urandom;
         case ($urandom_range(0, 3))
            0: begin
               rnd_a = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
               rnd_b = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
               rnd_c = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            end
            1: begin
               rnd_b = 0;
               rnd_c = 0;
            end
            default: ;
         endcase
         load_plane(rnd_a[23:0], rnd_b[23:0], rnd_c[23:0],
                    ($urandom_range(0, 3) == 0) ? $urandom
                       : $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000);
         rsp_stall_on = phase % 3 != 0;
         for (int k = 0; k < 40; k++) send_box(random_box());
      end

      wait_drained();

      $display("Checked %0d of %0d boxes across %0d plane settings.",
               board.checked, boxes_sent, plane_count + 1);
      if (board.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("Verification failed");
      end
      $finish;
   end
endmodule
